// ===== src/i2p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_pkg: shared types, constants and microcode for the infix-to-postfix block
// Character codes, operator stack codes, error codes, the sequencer control
// word layout and the microcode ROM contents.
// ----------------------------------------------------------------------------
package i2p_pkg;

   // characters of interest
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;

   // operator stack entry codes
   localparam logic [2:0] CODE_MINUS = 3'd1;
   localparam logic [2:0] CODE_PLUS  = 3'd2;
   localparam logic [2:0] CODE_MUL   = 3'd3;
   localparam logic [2:0] CODE_DIV   = 3'd4;
   localparam logic [2:0] CODE_OPEN  = 3'd5;

   // sticky error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_CLOSE    = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_OPEN     = 2'd3;

   // datapath actions
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_EMIT_SPACE,
      ACT_EMIT_CHAR,
      ACT_PUSH,
      ACT_POP_EMIT,
      ACT_CLOSE_END,
      ACT_SET_PENDING,
      ACT_FLUSH_POP,
      ACT_TERMINATE
   } act_type;

   // branch conditions
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_IN_VALID,
      C_HELD_SPACE,
      C_ABOVE_OPEN,
      C_TOP_MD,
      C_LAST,
      C_NOT_SPACE_LAST,
      C_NONEMPTY
   } cond_type;

   // next-step selection
   typedef enum logic [1:0] {
      NX_COND,
      NX_DISP,
      NX_END
   } nx_type;

   typedef logic [3:0] step_type;

   // microcode addresses
   localparam step_type S_IDLE    = 4'd0;
   localparam step_type S_HELD    = 4'd1;
   localparam step_type S_OPERAND = 4'd2;
   localparam step_type S_PM_POP  = 4'd3;
   localparam step_type S_PUSH    = 4'd4;
   localparam step_type S_MD_POP  = 4'd5;
   localparam step_type S_CL_POP  = 4'd6;
   localparam step_type S_CL_DROP = 4'd7;
   localparam step_type S_SP      = 4'd8;
   localparam step_type S_SP_LAST = 4'd9;
   localparam step_type S_SP_HOLD = 4'd10;
   localparam step_type S_FLUSH   = 4'd11;
   localparam step_type S_TERM    = 4'd12;

   // one control word
   typedef struct packed {
      act_type  act;
      cond_type cond;
      nx_type   nx;
      step_type t_true;
      step_type t_false;
   } uword_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic in_valid;
      logic held_space;
      logic is_pm;
      logic is_md;
      logic is_open;
      logic is_close;
      logic is_space;
      logic above_open;
      logic top_md;
      logic last;
      logic not_space_last;
      logic nonempty;
   } flags_type;

   // sequencer outputs to the datapath
   typedef struct packed {
      act_type act;
      logic    in_ready;
   } seq_out_type;

   // microcode ROM
   function automatic uword_type ucode(input step_type pc);
      uword_type w;
      unique case (pc)
         S_IDLE:    w = '{ACT_ACCEPT,      C_IN_VALID,       NX_COND, S_HELD,    S_IDLE};
         S_HELD:    w = '{ACT_EMIT_SPACE,  C_HELD_SPACE,     NX_DISP, S_IDLE,    S_IDLE};
         S_OPERAND: w = '{ACT_EMIT_CHAR,   C_ALWAYS,         NX_END,  S_IDLE,    S_IDLE};
         S_PM_POP:  w = '{ACT_POP_EMIT,    C_ABOVE_OPEN,     NX_COND, S_PM_POP,  S_PUSH};
         S_PUSH:    w = '{ACT_PUSH,        C_ALWAYS,         NX_END,  S_IDLE,    S_IDLE};
         S_MD_POP:  w = '{ACT_POP_EMIT,    C_TOP_MD,         NX_COND, S_MD_POP,  S_PUSH};
         S_CL_POP:  w = '{ACT_POP_EMIT,    C_ABOVE_OPEN,     NX_COND, S_CL_POP,  S_CL_DROP};
         S_CL_DROP: w = '{ACT_CLOSE_END,   C_ALWAYS,         NX_END,  S_IDLE,    S_IDLE};
         S_SP:      w = '{ACT_NONE,        C_LAST,           NX_COND, S_SP_LAST, S_SP_HOLD};
         S_SP_LAST: w = '{ACT_EMIT_SPACE,  C_NOT_SPACE_LAST, NX_END,  S_IDLE,    S_IDLE};
         S_SP_HOLD: w = '{ACT_SET_PENDING, C_ALWAYS,         NX_END,  S_IDLE,    S_IDLE};
         S_FLUSH:   w = '{ACT_FLUSH_POP,   C_NONEMPTY,       NX_COND, S_FLUSH,   S_TERM};
         S_TERM:    w = '{ACT_TERMINATE,   C_ALWAYS,         NX_COND, S_IDLE,    S_IDLE};
         default:   w = '{ACT_NONE,        C_ALWAYS,         NX_COND, S_IDLE,    S_IDLE};
      endcase
      return w;
   endfunction

   // stack code for an operator or open parenthesis
   function automatic logic [2:0] code_of(input logic [7:0] c);
      logic [2:0] code;
      unique case (c)
         CHAR_MINUS: code = CODE_MINUS;
         CHAR_PLUS:  code = CODE_PLUS;
         CHAR_MUL:   code = CODE_MUL;
         CHAR_DIV:   code = CODE_DIV;
         default:    code = CODE_OPEN;
      endcase
      return code;
   endfunction

   // character for a stacked operator
   function automatic logic [7:0] char_of(input logic [2:0] code);
      logic [7:0] c;
      unique case (code)
         CODE_MINUS: c = CHAR_MINUS;
         CODE_PLUS:  c = CHAR_PLUS;
         CODE_MUL:   c = CHAR_MUL;
         default:    c = CHAR_DIV;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/i2p_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_ram: generic single-write, single-read RAM
// Registered read; a read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire logic [WIDTH-1:0]                  wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
   output      logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read with write-through
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data <= wr_data;
      end else begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/i2p_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2p_seq: microcode sequencer
// Step counter over the microcode ROM; picks the action and the next step
// from the datapath flags. A hold from the datapath freezes the step.
// ----------------------------------------------------------------------------
module i2p_seq
   import i2p_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire flags_type   flags,
   input  wire logic        hold,
   output      seq_out_type ctrl
);

   step_type  pc_ff;
   step_type  pc_in;
   uword_type word;
   logic      cond_ok;
   step_type  disp_step;

   assign word = ucode(pc_ff);

   // condition select
   always_comb begin
      unique case (word.cond)
         C_ALWAYS:         cond_ok = 1'b1;
         C_IN_VALID:       cond_ok = flags.in_valid;
         C_HELD_SPACE:     cond_ok = flags.held_space;
         C_ABOVE_OPEN:     cond_ok = flags.above_open;
         C_TOP_MD:         cond_ok = flags.top_md;
         C_LAST:           cond_ok = flags.last;
         C_NOT_SPACE_LAST: cond_ok = flags.not_space_last;
         C_NONEMPTY:       cond_ok = flags.nonempty;
         default:          cond_ok = 1'b0;
      endcase
   end

   // dispatch on the character class
   always_comb begin
      priority if (flags.is_pm)    disp_step = S_PM_POP;
      else if (flags.is_md)        disp_step = S_MD_POP;
      else if (flags.is_open)      disp_step = S_PUSH;
      else if (flags.is_close)     disp_step = S_CL_POP;
      else if (flags.is_space)     disp_step = S_SP;
      else                         disp_step = S_OPERAND;
   end

   // next step
   always_comb begin
      unique case (word.nx)
         NX_COND: pc_in = cond_ok ? word.t_true : word.t_false;
         NX_DISP: pc_in = disp_step;
         NX_END:  pc_in = flags.last ? S_FLUSH : S_IDLE;
         default: pc_in = S_IDLE;
      endcase
   end

   assign ctrl.act      = cond_ok ? word.act : ACT_NONE;
   assign ctrl.in_ready = (word.act == ACT_ACCEPT);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else if (!hold) begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: streaming infix to postfix conversion
// Operator stack in RAM driven by a microcoded sequencer; one result register.
// ----------------------------------------------------------------------------
// Takes one ASCII character per item and returns the postfix characters it
// releases, one per result item; the item marked last ends the expression,
// flushes the operator stack and returns a zero terminator with tlast set,
// after which the stack count, error, pending space and last emitted
// character are back to reset. Each result carries the first error of the
// expression so far (unmatched close, stack overflow, unmatched open).
// Characters are taken one at a time: an operator first pops the stacked
// operators of equal or higher precedence down to an open parenthesis, a
// close parenthesis pops down to its open one, and the last character then
// pops every stacked entry before the terminator. The pops run one per
// cycle through the stack RAM's single read port, and any cycle that
// returns a result waits while the result register is still full.
module infix_to_postfix_converter
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] out_char
   output      logic       rsp_tlast,
   output      logic [1:0] rsp_tuser    // [1:0] error_code
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   seq_out_type ctrl;
   flags_type   flags;
   logic        hold;

   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        held_ff, held_in;
   logic        pending_ff, pending_in;
   logic [7:0]  last_em_ff, last_em_in;
   logic [1:0]  err_ff, err_in;
   logic [CW-1:0] count_ff, count_in, count_nx;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff;
   logic        rsp_last_ff;
   logic [1:0]  rsp_err_ff;

   logic        emit_req, emit_last, emit_ok;
   logic [7:0]  emit_char;
   logic        push_we;
   logic [2:0]  top_code;
   logic        nonempty;
   logic        is_pm, is_md;

   // sequencer
   i2p_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .hold  (hold),
      .ctrl  (ctrl)
   );

   // operator stack
   i2p_ram #(
      .WIDTH (3),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push_we && !hold),
      .wr_addr (AW'(count_ff)),
      .wr_data (code_of(char_ff)),
      .rd_addr (AW'(count_nx - 1'b1)),
      .rd_data (top_code)
   );

   // status for the sequencer
   assign nonempty = (count_ff != '0);
   assign is_pm    = (char_ff == CHAR_PLUS) || (char_ff == CHAR_MINUS);
   assign is_md    = (char_ff == CHAR_MUL) || (char_ff == CHAR_DIV);

   always_comb begin
      flags.in_valid       = req_tvalid;
      flags.held_space     = held_ff && !is_pm && !is_md && (last_em_ff != CHAR_SPACE);
      flags.is_pm          = is_pm;
      flags.is_md          = is_md;
      flags.is_open        = (char_ff == CHAR_OPEN);
      flags.is_close       = (char_ff == CHAR_CLOSE);
      flags.is_space       = (char_ff == CHAR_SPACE);
      flags.above_open     = nonempty && (top_code != CODE_OPEN);
      flags.top_md         = nonempty && ((top_code == CODE_MUL) || (top_code == CODE_DIV));
      flags.last           = last_ff;
      flags.not_space_last = (last_em_ff != CHAR_SPACE);
      flags.nonempty       = nonempty;
   end

   assign req_tready = ctrl.in_ready;

   // datapath actions
   always_comb begin
      char_in    = char_ff;
      last_in    = last_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      err_in     = err_ff;
      count_in   = count_ff;
      emit_req   = 1'b0;
      emit_char  = CHAR_NUL;
      emit_last  = 1'b0;
      push_we    = 1'b0;
      unique case (ctrl.act)
         ACT_NONE: begin
         end
         ACT_ACCEPT: begin
            char_in    = req_tdata;
            last_in    = req_tlast;
            held_in    = pending_ff;
            pending_in = 1'b0;
         end
         ACT_EMIT_SPACE: begin
            emit_req  = 1'b1;
            emit_char = CHAR_SPACE;
         end
         ACT_EMIT_CHAR: begin
            emit_req  = 1'b1;
            emit_char = char_ff;
         end
         ACT_PUSH: begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               if (err_ff == ERR_NONE) err_in = ERR_OVERFLOW;
            end else begin
               push_we  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP_EMIT: begin
            emit_req  = 1'b1;
            emit_char = char_of(top_code);
            count_in  = count_ff - 1'b1;
         end
         ACT_CLOSE_END: begin
            if (!nonempty) begin
               if (err_ff == ERR_NONE) err_in = ERR_CLOSE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ACT_SET_PENDING: begin
            pending_in = 1'b1;
         end
         ACT_FLUSH_POP: begin
            count_in = count_ff - 1'b1;
            if (top_code == CODE_OPEN) begin
               if (err_ff == ERR_NONE) err_in = ERR_OPEN;
            end else begin
               emit_req  = 1'b1;
               emit_char = char_of(top_code);
            end
         end
         ACT_TERMINATE: begin
            emit_req   = 1'b1;
            emit_char  = CHAR_NUL;
            emit_last  = 1'b1;
            count_in   = '0;
            pending_in = 1'b0;
            err_in     = ERR_NONE;
         end
         default: begin
         end
      endcase
   end

   // stall while the result register is still full
   assign emit_ok  = !rsp_valid_ff || rsp_tready;
   assign hold     = emit_req && !emit_ok;
   assign count_nx = hold ? count_ff : count_in;

   // last emitted character; cleared at the end of the expression
   always_comb begin
      if (ctrl.act == ACT_TERMINATE) begin
         last_em_in = CHAR_NUL;
      end else if (emit_req) begin
         last_em_in = emit_char;
      end else begin
         last_em_in = last_em_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         last_em_ff <= CHAR_NUL;
         err_ff     <= ERR_NONE;
         count_ff   <= '0;
         held_ff    <= 1'b0;
         last_ff    <= 1'b0;
      end else if (!hold) begin
         pending_ff <= pending_in;
         last_em_ff <= last_em_in;
         err_ff     <= err_in;
         count_ff   <= count_in;
         held_ff    <= held_in;
         last_ff    <= last_in;
      end
   end

   // current character
   always_ff @(posedge clock) begin
      if (!hold) begin
         char_ff <= char_in;
      end
   end

   // result register
   always_comb begin
      if (emit_req) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_req && emit_ok) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // stack fill never passes its depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // a terminator result is always the zero character
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == CHAR_NUL))
      else $error("terminator carries a nonzero character");

   // the terminator leaves the expression state cleared
   a_term_clear: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.act == ACT_TERMINATE) && !hold) |=>
         ((count_ff == '0) && (err_ff == ERR_NONE) && !pending_ff))
      else $error("state not cleared after terminator");

   // one character at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while an item is in work");

endmodule
`default_nettype wire
